// ===== rtl/core/pvpi_pkg.sv =====
package pvpi_pkg;

    localparam int TIME_W  = 32;
    localparam int HEAD_W  = 16;
    localparam int SPEED_W = 32;
    localparam int OUT_W   = 48;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 1;

    // CORDIC datapath: Q2.30 x/y with headroom, angle in 2^32 units per turn
    localparam int CORD_W  = 33;
    localparam int ANG_W   = 34;
    localparam int MAG_W   = 31;
    localparam int ATAN_W  = 30;

    localparam logic signed [CORD_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [CORD_W-1:0] ONE_Q30  = 33'sd1073741824;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [IDX_W-1:0] REG_START_X = 1'b0;
    localparam logic [IDX_W-1:0] REG_START_Y = 1'b1;

    localparam logic [ATAN_W-1:0] ATAN_TURN [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // Cosine and sine as magnitude and sign, plus the done flag
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] c_mag;
        logic             c_neg;
        logic [MAG_W-1:0] s_mag;
        logic             s_neg;
    } cordic_res_t;

endpackage

// ===== rtl/core/pvpi_tick_if.sv =====
interface pvpi_tick_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [31:0]        time_stamp;
    logic [15:0]        heading;
    logic signed [31:0] speed;

    modport source (output valid, operation, time_stamp, heading, speed, input ready);
    modport sink   (input valid, operation, time_stamp, heading, speed, output ready);
endinterface

// ===== rtl/core/pvpi_pos_if.sv =====
interface pvpi_pos_if;
    logic        valid;
    logic        ready;
    logic [47:0] pos_x;
    logic [47:0] pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

// ===== rtl/core/pvpi_cordic.sv =====
module pvpi_cordic
    import pvpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HEAD_W-1:0] heading,
    output cordic_res_t       res
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                     busy_reg, busy_next;
    logic                     fix_reg, fix_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic [MAG_W-1:0]         c_mag_reg, c_mag_next;
    logic                     c_neg_reg, c_neg_next;
    logic [MAG_W-1:0]         s_mag_reg, s_mag_next;
    logic                     s_neg_reg, s_neg_next;

    logic [31:0]              ang;
    logic                     flip_in;
    logic signed [CORD_W-1:0] xs, ys, xc, yc;
    logic signed [ANG_W-1:0]  atan_s;

    assign flip_in = heading[15] ^ heading[14];
    assign ang     = {heading, 16'd0} ^ {flip_in, 31'd0};
    assign xs      = x_reg >>> step_reg;
    assign ys      = y_reg >>> step_reg;
    assign atan_s  = ANG_W'(ATAN_TURN[5'(step_reg)]);

    always_comb
    begin
        // clamp to +-1.0
        if (x_reg > ONE_Q30)
            xc = ONE_Q30;
        else if (x_reg < -ONE_Q30)
            xc = -ONE_Q30;
        else
            xc = x_reg;
        if (y_reg > ONE_Q30)
            yc = ONE_Q30;
        else if (y_reg < -ONE_Q30)
            yc = -ONE_Q30;
        else
            yc = y_reg;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        fix_next   = 1'b0;
        done_next  = done_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        c_mag_next = c_mag_reg;
        c_neg_next = c_neg_reg;
        s_mag_next = s_mag_reg;
        s_neg_next = s_neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            x_next    = GAIN_Q30;
            y_next    = '0;
            z_next    = ANG_W'(signed'(ang));
            flip_next = flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_s;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_s;
            end
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
            else
                step_next = step_reg + 1'b1;
        end
        else if (fix_reg)
        begin
            // a zero magnitude makes the sign irrelevant downstream
            c_mag_next = MAG_W'(xc[CORD_W-1] ? -xc : xc);
            c_neg_next = flip_reg ^ xc[CORD_W-1];
            s_mag_next = MAG_W'(yc[CORD_W-1] ? -yc : yc);
            s_neg_next = flip_reg ^ yc[CORD_W-1];
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        flip_reg  <= flip_next;
        c_mag_reg <= c_mag_next;
        c_neg_reg <= c_neg_next;
        s_mag_reg <= s_mag_next;
        s_neg_reg <= s_neg_next;
    end

    assign res.done  = done_reg;
    assign res.c_mag = c_mag_reg;
    assign res.c_neg = c_neg_reg;
    assign res.s_mag = s_mag_reg;
    assign res.s_neg = s_neg_reg;

endmodule

// ===== rtl/core/polar_velocity_position_integrator.sv =====
// Dead-reckoning integrator: one tick beat in, at most one position beat out.
// A moving tick holds tick.ready low from accept until its position is registered, set by the
// CORDIC iteration loop, by the one shared 32x32 multiplier (distance product, then four
// partial products) and by pos back-pressure; restart and first tick do not leave idle.
// Reset (rst_n, asynchronous, active low) clears start and current position,
// the last time and the time-seen flag; no memory, no clearing pass.
module polar_velocity_position_integrator
    import pvpi_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int POSITION_BITS = 48
)
(
    input  logic             clk,
    input  logic             rst_n,
    pvpi_tick_if.sink        tick,
    pvpi_pos_if.source       pos,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int PB = POSITION_BITS;

    // Position limits, kept in a wide signed frame for compare
    localparam logic signed [64:0] PMAX = (65'sd1 <<< (PB - 1)) - 65'sd1;
    localparam logic signed [64:0] PMIN = -PMAX - 65'sd1;
    localparam logic signed [65:0] PMAX_W = 66'(PMAX);
    localparam logic signed [65:0] PMIN_W = 66'(PMIN);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DMUL = 4'd1;
    localparam logic [3:0] S_DRND = 4'd2;
    localparam logic [3:0] S_WAIT = 4'd3;
    localparam logic [3:0] S_MHI  = 4'd4;
    localparam logic [3:0] S_MLO  = 4'd5;
    localparam logic [3:0] S_RND  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [79:0] HALF_Q30 = 80'd1 << 29;

    // Control state
    logic [3:0]             state_reg, state_next;
    logic                   axis_reg, axis_next;
    logic                   time_seen_reg, time_seen_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [PB-1:0]   start_x_reg, start_x_next;
    logic signed [PB-1:0]   start_y_reg, start_y_next;
    logic signed [PB-1:0]   cur_x_reg, cur_x_next;
    logic signed [PB-1:0]   cur_y_reg, cur_y_next;
    logic [TIME_W-1:0]      prev_time_reg, prev_time_next;

    // Datapath
    logic [31:0]            us_reg, us_next;
    logic [31:0]            ut_reg, ut_next;
    logic                   dneg_reg, dneg_next;
    logic [47:0]            mag_reg, mag_next;
    logic [63:0]            prod_reg, prod_next;
    logic [79:0]            acc_reg, acc_next;
    logic [OUT_W-1:0]       out_x_reg, out_x_next;
    logic [OUT_W-1:0]       out_y_reg, out_y_next;

    logic                   tick_accept;
    logic                   cordic_start;
    cordic_res_t            cres;

    logic signed [32:0]     dt;
    logic [31:0]            mul_a, mul_b;
    logic [MAG_W-1:0]       trig_mag;
    logic                   delta_neg;
    logic signed [65:0]     r_ext, delta, cur_sel, sum, sat;
    logic signed [64:0]     cfg_ext, cfg_clamp;
    logic signed [63:0]     cx_ext, cy_ext;

    pvpi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .heading (tick.heading),
        .res     (cres)
    );

    assign tick.ready  = (state_reg == S_IDLE);
    assign tick_accept = tick.valid && tick.ready;
    assign cordic_start = tick_accept && (tick.operation == OP_TICK) && time_seen_reg;

    assign pos.valid = out_valid_reg;
    assign pos.pos_x = out_x_reg;
    assign pos.pos_y = out_y_reg;

    // Signed time difference, full 33 bits
    assign dt = 33'(signed'({1'b0, tick.time_stamp})) - 33'(signed'({1'b0, prev_time_reg}));

    // Shared multiplier: distance first, then 24-bit halves of it by cos/sin
    assign trig_mag = axis_reg ? cres.s_mag : cres.c_mag;
    always_comb
    begin
        unique case (state_reg)
            S_DMUL:
            begin
                mul_a = us_reg;
                mul_b = ut_reg;
            end
            S_MHI:
            begin
                mul_a = {8'd0, mag_reg[47:24]};
                mul_b = {1'b0, trig_mag};
            end
            default:
            begin
                mul_a = {8'd0, mag_reg[23:0]};
                mul_b = {1'b0, trig_mag};
            end
        endcase
    end

    // Rounded displacement, signed, then saturating add onto the axis
    assign delta_neg = dneg_reg ^ (axis_reg ? cres.s_neg : cres.c_neg);
    assign r_ext     = 66'({1'b0, acc_reg[79:30]});
    assign delta     = delta_neg ? -r_ext : r_ext;
    assign cur_sel   = axis_reg ? 66'(cur_y_reg) : 66'(cur_x_reg);
    assign sum       = cur_sel + delta;
    assign sat       = (sum > PMAX_W) ? PMAX_W : ((sum < PMIN_W) ? PMIN_W : sum);

    // Config data sign-extended from 48 bits, clamped to the position range
    assign cfg_ext   = 65'(signed'(cfg_data));
    assign cfg_clamp = (cfg_ext > PMAX) ? PMAX : ((cfg_ext < PMIN) ? PMIN : cfg_ext);

    assign cx_ext = 64'(cur_x_reg);
    assign cy_ext = 64'(cur_y_reg);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        time_seen_next = time_seen_reg;
        out_valid_next = out_valid_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prev_time_next = prev_time_reg;
        us_next        = us_reg;
        ut_next        = ut_reg;
        dneg_next      = dneg_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;

        // drop the output beat once taken
        if (pos.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_accept)
                begin
                    if (tick.operation == OP_RESTART)
                    begin
                        cur_x_next     = start_x_reg;
                        cur_y_next     = start_y_reg;
                        time_seen_next = 1'b0;
                    end
                    else if (!time_seen_reg)
                    begin
                        // first tick only records the time
                        prev_time_next = tick.time_stamp;
                        time_seen_next = 1'b1;
                    end
                    else
                    begin
                        prev_time_next = tick.time_stamp;
                        us_next   = tick.speed[31] ? 32'(-tick.speed) : 32'(tick.speed);
                        ut_next   = dt[32] ? 32'(-dt) : 32'(dt);
                        dneg_next = tick.speed[31] ^ dt[32];
                        axis_next = 1'b0;
                        state_next = S_DMUL;
                    end
                end
            end
            S_DMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_DRND;
            end
            S_DRND:
            begin
                mag_next   = 48'((prod_reg + 64'd32768) >> 16);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (cres.done)
                    state_next = S_MHI;
            end
            S_MHI:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                acc_next   = 80'(prod_reg) << 24;
                prod_next  = mul_a * mul_b;
                state_next = S_RND;
            end
            S_RND:
            begin
                acc_next   = acc_reg + 80'(prod_reg) + HALF_Q30;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (axis_reg)
                begin
                    cur_y_next = PB'(sat);
                    state_next = S_OUT;
                end
                else
                begin
                    cur_x_next = PB'(sat);
                    axis_next  = 1'b1;
                    state_next = S_MHI;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || pos.ready)
                begin
                    out_x_next     = cx_ext[OUT_W-1:0];
                    out_y_next     = cy_ext[OUT_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // start register writes also load the current coordinate
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_X:
                begin
                    start_x_next = PB'(cfg_clamp);
                    cur_x_next   = PB'(cfg_clamp);
                end
                REG_START_Y:
                begin
                    start_y_next = PB'(cfg_clamp);
                    cur_y_next   = PB'(cfg_clamp);
                end
                default:
                begin
                    start_x_next = start_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            time_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            prev_time_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            time_seen_reg <= time_seen_next;
            out_valid_reg <= out_valid_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            prev_time_reg <= prev_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        us_reg    <= us_next;
        ut_reg    <= ut_next;
        dneg_reg  <= dneg_next;
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

endmodule
